>>> hw/rtl/crc_comb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crc_comb_pkg;

    localparam int CRC_WIDTH   = 32;
    localparam int LENGTH_BITS = 32;

    localparam logic [CRC_WIDTH-1:0] REFLECTED_POLY = 32'hEDB88320;

    // one zero bit squared three times gives one zero byte
    localparam int BYTE_SQUARINGS = 3;

    typedef logic [CRC_WIDTH-1:0] crc_t;
    typedef logic [LENGTH_BITS-1:0] len_t;
    // column k is the image of bit k
    typedef crc_t [CRC_WIDTH-1:0] gf2_mat_t;
    typedef gf2_mat_t [LENGTH_BITS-1:0] zero_op_tab_t;

    function automatic crc_t gf2_apply(input gf2_mat_t mat, input crc_t vec);
        crc_t acc;
        acc = '0;
        for (int k = 0; k < CRC_WIDTH; k++)
        begin
            if (vec[k])
            begin
                acc = acc ^ mat[k];
            end
        end
        return acc;
    endfunction

    function automatic gf2_mat_t gf2_square(input gf2_mat_t src);
        gf2_mat_t dst;
        for (int k = 0; k < CRC_WIDTH; k++)
        begin
            dst[k] = gf2_apply(src, src[k]);
        end
        return dst;
    endfunction

    // entry i advances a crc over 2^i zero bytes
    function automatic zero_op_tab_t build_zero_ops();
        zero_op_tab_t tab;
        gf2_mat_t     cur;
        cur[0] = REFLECTED_POLY;
        for (int k = 1; k < CRC_WIDTH; k++)
        begin
            cur[k] = crc_t'(1) << (k - 1);
        end
        for (int k = 0; k < BYTE_SQUARINGS; k++)
        begin
            cur = gf2_square(cur);
        end
        for (int i = 0; i < LENGTH_BITS; i++)
        begin
            tab[i] = cur;
            cur    = gf2_square(cur);
        end
        return tab;
    endfunction

    localparam zero_op_tab_t ZERO_OPS = build_zero_ops();

endpackage

`default_nettype wire

>>> hw/rtl/crc32_combine_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   handshake              payload
// input     in_valid / in_ready    crc_first, crc_second, second_length
// output    out_valid / out_ready  combined_crc
//
// one word enters per cycle while in_ready is high; LENGTH_BITS + 1 register stages,
// one per length bit, each a constant gf(2) 32x32 xor tree, then the output
// register, and a word taken passes through them in that order.
// the whole pipeline moves on one enable: it advances when the output register
// is empty or being taken, and in_ready is that enable.
// reset clears the valid bits only; nothing is lost or repeated on a stall.
module crc32_combine_core
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [31:0]                    crc_first,
    input  wire logic [31:0]                    crc_second,
    input  wire logic [31:0]                    second_length,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [crc_comb_pkg::CRC_WIDTH-1:0]  combined_crc
);

    import crc_comb_pkg::*;

    logic advance;

    logic [LENGTH_BITS-1:0] valid_reg;
    crc_t                   crc_reg    [LENGTH_BITS];
    crc_t                   second_reg [LENGTH_BITS];
    len_t                   len_reg    [LENGTH_BITS];

    crc_t stage_crc_in    [LENGTH_BITS];
    crc_t stage_second_in [LENGTH_BITS];
    len_t stage_len_in    [LENGTH_BITS];
    logic stage_valid_in  [LENGTH_BITS];
    crc_t crc_next        [LENGTH_BITS];

    logic out_valid_reg;
    crc_t combined_crc_reg;
    crc_t combined_crc_next;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        stage_crc_in[0]    = crc_first;
        stage_second_in[0] = crc_second;
        stage_len_in[0]    = second_length[LENGTH_BITS-1:0];
        stage_valid_in[0]  = in_valid;
        for (int k = 1; k < LENGTH_BITS; k++)
        begin
            stage_crc_in[k]    = crc_reg[k-1];
            stage_second_in[k] = second_reg[k-1];
            stage_len_in[k]    = len_reg[k-1];
            stage_valid_in[k]  = valid_reg[k-1];
        end
        for (int k = 0; k < LENGTH_BITS; k++)
        begin
            // skip the operator when this length bit is clear
            if (stage_len_in[k][k])
            begin
                crc_next[k] = gf2_apply(ZERO_OPS[k], stage_crc_in[k]);
            end
            else
            begin
                crc_next[k] = stage_crc_in[k];
            end
        end
        combined_crc_next = crc_reg[LENGTH_BITS-1] ^ second_reg[LENGTH_BITS-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            for (int k = 0; k < LENGTH_BITS; k++)
            begin
                valid_reg[k] <= stage_valid_in[k];
            end
            out_valid_reg <= valid_reg[LENGTH_BITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < LENGTH_BITS; k++)
            begin
                crc_reg[k]    <= crc_next[k];
                second_reg[k] <= stage_second_in[k];
                len_reg[k]    <= stage_len_in[k];
            end
            combined_crc_reg <= combined_crc_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign combined_crc = combined_crc_reg;

endmodule

`default_nettype wire
